FILE: hw/rtl/skd_pkg.sv
// Package with the shared types, constants and key table of the keypad scanner.
package skd_pkg;

	localparam int unsigned SHIFT_WIDTH = 8;
	localparam int unsigned BITS_W      = 4;
	localparam int unsigned KEY_COUNT   = 20;

	localparam logic [7:0]  PATTERN_ALL_LOW  = 8'h00;
	localparam logic [7:0]  PATTERN_ALL_HIGH = 8'hFF;
	localparam logic [15:0] DEBOUNCE_RESET   = 16'd20000;

	// Register map: one register, selected by address bit 2.
	localparam logic REG_DEBOUNCE = 1'b0;

	typedef enum logic [5:0] {
		PH_IDLE      = 6'b000001,
		PH_SHIFT_ALL = 6'b000010,
		PH_SAMPLE    = 6'b000100,
		PH_WAIT      = 6'b001000,
		PH_SHIFT_ROW = 6'b010000,
		PH_CHECK_ROW = 6'b100000
	} scan_phase_t;

	// Character printed on each key; indexes past the table read as zero.
	function automatic logic [7:0] key_char_f(input logic [4:0] idx);
		logic [7:0] ch;
		case (idx)
			5'd0:    ch = "0";
			5'd1:    ch = "1";
			5'd2:    ch = "2";
			5'd3:    ch = "3";
			5'd4:    ch = "4";
			5'd5:    ch = "5";
			5'd6:    ch = "6";
			5'd7:    ch = "7";
			5'd8:    ch = "8";
			5'd9:    ch = "9";
			5'd10:   ch = ".";
			5'd11:   ch = "=";
			5'd12:   ch = "+";
			5'd13:   ch = "-";
			5'd14:   ch = "*";
			5'd15:   ch = "/";
			5'd16:   ch = "^";
			5'd17:   ch = "#";
			5'd18:   ch = "s";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/skd_in_if.sv
// Input channel interface of the keypad scanner: one tick word with pin levels.
interface skd_in_if;
	logic       valid;
	logic       ready;
	logic       start_scan;
	logic [3:0] column_levels;

	modport source (output valid, output start_scan, output column_levels, input ready);
	modport sink   (input valid, input start_scan, input column_levels, output ready);
endinterface

FILE: hw/rtl/skd_out_if.sv
// Output channel interface of the keypad scanner: pin levels and scan verdict.
interface skd_out_if;
	logic       valid;
	logic       ready;
	logic       shift_clock;
	logic       shift_data;
	logic       busy_res;
	logic       scan_done;
	logic       key_found;
	logic [4:0] key_index;
	logic [7:0] key_char;

	modport source (output valid, output shift_clock, output shift_data, output busy_res,
		output scan_done, output key_found, output key_index, output key_char,
		input ready);
	modport sink (input valid, input shift_clock, input shift_data, input busy_res,
		input scan_done, input key_found, input key_index, input key_char,
		output ready);
endinterface

FILE: hw/rtl/shift_driven_keypad_scanner.sv
// Top level of the shift-register driven matrix keypad scanner.
//
//  Channel   Dir  Handshake        Word contents
//  scan_in   in   valid / ready    start_scan, column_levels (one timer tick)
//  scan_out  out  valid / ready    shift_clock, shift_data, busy_res, scan_done,
//                                  key_found, key_index, key_char
//  apb       in   psel / penable   debounce_ticks register at byte address 0
//
// Every accepted tick word yields exactly one result word, after it has passed through
// the input register and then the result register.
// Sustained rate is one word per cycle while scan_out is ready; the scan state is updated
// in the same cycle that a word moves from the input register into the result register.
// A stall on scan_out holds the result register, and the input register keeps its
// word, so scan_in drops ready only when both are full and the sink is not ready.
// Reset (arst_n low, asynchronous) empties both registers and returns the scanner
// to idle with the clock pin high and data low.
module shift_driven_keypad_scanner
	import skd_pkg::*;
#(
	parameter int unsigned ROW_COUNT    = 5,
	parameter int unsigned COLUMN_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	skd_in_if.sink      scan_in,
	skd_out_if.source   scan_out
);

	localparam logic [COLUMN_COUNT-1:0] COL_ALL_HIGH = '1;

	logic [15:0] debounce_ticks;

	skd_cfg_regs u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.debounce_ticks (debounce_ticks)
	);

	// Input register stage.
	logic                    valid_s1;
	logic                    start_s1;
	logic [COLUMN_COUNT-1:0] cols_s1;

	// Result register stage.
	logic       valid_s2;
	logic       clk_pin_s2;
	logic       data_pin_s2;
	logic       busy_s2;
	logic       done_s2;
	logic       found_s2;
	logic [4:0] index_s2;
	logic [7:0] char_s2;

	// Scan state.
	scan_phase_t             phase_q;
	logic [7:0]              pattern_q;
	logic [BITS_W-1:0]       bits_q;
	logic                    half_q;
	logic [15:0]             wait_q;
	logic [COLUMN_COUNT-1:0] captured_q;
	logic [2:0]              row_q;
	logic [1:0]              col_q;

	logic in_take;
	logic advance;

	assign advance       = valid_s1 && (!valid_s2 || scan_out.ready);
	assign in_take       = scan_in.valid && scan_in.ready;
	assign scan_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= scan_in.start_scan;
			cols_s1  <= scan_in.column_levels[COLUMN_COUNT-1:0];
		end
	end

	// First low captured column at or above the given one; bit 2 flags a hit.
	function automatic logic [2:0] next_low_col(input logic [COLUMN_COUNT-1:0] cap,
		input logic [2:0] from);
		logic [2:0] res;
		res = 3'b000;
		for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
			if (3'(c) >= from && !cap[c]) begin
				res = {1'b1, 2'(c)};
			end
		end
		return res;
	endfunction

	// Next-state and result logic for the word leaving the input register.
	scan_phase_t             phase_d;
	logic [7:0]              pattern_d;
	logic [BITS_W-1:0]       bits_d;
	logic [BITS_W-1:0]       bits_dec;
	logic                    half_d;
	logic [15:0]             wait_d;
	logic [COLUMN_COUNT-1:0] captured_d;
	logic [2:0]              row_d;
	logic [1:0]              col_d;
	logic                    clk_pin;
	logic                    data_pin;
	logic                    done;
	logic                    found;
	logic [4:0]              key_idx;
	logic [2:0]              low_col;
	logic [2:0]              row_inc;

	assign key_idx  = {row_q, 2'b00} + {3'b000, col_q};
	assign bits_dec = (bits_q != '0) ? bits_q - 1'b1 : '0;
	assign row_inc  = row_q + 3'd1;

	always_comb begin
		phase_d    = phase_q;
		pattern_d  = pattern_q;
		bits_d     = bits_q;
		half_d     = half_q;
		wait_d     = wait_q;
		captured_d = captured_q;
		row_d      = row_q;
		col_d      = col_q;
		clk_pin    = half_q;
		data_pin   = pattern_q[0];
		done       = 1'b0;
		found      = 1'b0;
		low_col    = 3'b000;

		case (phase_q)
			PH_IDLE: begin
				if (start_s1) begin
					pattern_d = PATTERN_ALL_LOW;
					bits_d    = BITS_W'(SHIFT_WIDTH);
					phase_d   = PH_SHIFT_ALL;
				end
			end
			PH_SHIFT_ALL, PH_SHIFT_ROW: begin
				data_pin = pattern_q[7];
				if (bits_q != '0 && half_q) begin
					// Falling half of the bit: present data with the clock low.
					clk_pin = 1'b0;
					half_d  = 1'b0;
				end else begin
					// Rising half: the external register takes the bit.
					clk_pin   = 1'b1;
					half_d    = 1'b1;
					pattern_d = {pattern_q[6:0], pattern_q[7]};
					bits_d    = bits_dec;
					if (bits_dec == '0) begin
						phase_d = (phase_q == PH_SHIFT_ALL) ? PH_SAMPLE : PH_CHECK_ROW;
					end
				end
			end
			PH_SAMPLE: begin
				if (cols_s1 == COL_ALL_HIGH) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					captured_d = cols_s1;
					wait_d     = debounce_ticks;
					phase_d    = PH_WAIT;
				end
			end
			PH_WAIT: begin
				low_col = next_low_col(captured_q, 3'd0);
				if (wait_q != 16'd0) begin
					wait_d = wait_q - 16'd1;
				end else if (cols_s1 != captured_q || !low_col[2]) begin
					// Bounce, or nothing low to search: no key.
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					col_d     = low_col[1:0];
					row_d     = 3'd0;
					pattern_d = PATTERN_ALL_HIGH ^ 8'h01;
					bits_d    = BITS_W'(SHIFT_WIDTH);
					phase_d   = PH_SHIFT_ROW;
				end
			end
			PH_CHECK_ROW: begin
				low_col = next_low_col(captured_q, {1'b0, col_q} + 3'd1);
				if (cols_s1 == captured_q) begin
					done    = 1'b1;
					found   = 1'b1;
					phase_d = PH_IDLE;
				end else if ({1'b0, row_inc} < 4'(ROW_COUNT) && row_inc != 3'd0) begin
					row_d     = row_inc;
					pattern_d = PATTERN_ALL_HIGH ^ (8'd1 << row_inc);
					bits_d    = BITS_W'(SHIFT_WIDTH);
					phase_d   = PH_SHIFT_ROW;
				end else if (!low_col[2]) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					col_d     = low_col[1:0];
					row_d     = 3'd0;
					pattern_d = PATTERN_ALL_HIGH ^ 8'h01;
					bits_d    = BITS_W'(SHIFT_WIDTH);
					phase_d   = PH_SHIFT_ROW;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pattern_q  <= PATTERN_ALL_LOW;
			bits_q     <= '0;
			half_q     <= 1'b1;
			wait_q     <= 16'd0;
			captured_q <= COL_ALL_HIGH;
			row_q      <= 3'd0;
			col_q      <= 2'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			pattern_q  <= pattern_d;
			bits_q     <= bits_d;
			half_q     <= half_d;
			wait_q     <= wait_d;
			captured_q <= captured_d;
			row_q      <= row_d;
			col_q      <= col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (scan_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clk_pin_s2  <= clk_pin;
			data_pin_s2 <= data_pin;
			busy_s2     <= (phase_d != PH_IDLE);
			done_s2     <= done;
			found_s2    <= found;
			index_s2    <= found ? key_idx : 5'd0;
			char_s2     <= found ? key_char_f(key_idx) : 8'h00;
		end
	end

	assign scan_out.valid       = valid_s2;
	assign scan_out.shift_clock = clk_pin_s2;
	assign scan_out.shift_data  = data_pin_s2;
	assign scan_out.busy_res    = busy_s2;
	assign scan_out.scan_done   = done_s2;
	assign scan_out.key_found   = found_s2;
	assign scan_out.key_index   = index_s2;
	assign scan_out.key_char    = char_s2;

	// A verdict always ends the scan.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> !busy_s2)
		else $error("scan_done reported while still busy");

	// A found key is only ever reported together with a verdict.
	a_found_has_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && found_s2) |-> done_s2)
		else $error("key_found without scan_done");

	// The reported row lies on the keypad.
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && found_s2) |-> ({1'b0, index_s2[4:2]} < 4'(ROW_COUNT)))
		else $error("key_index names a row beyond the keypad");

	// Bits remain to be shifted only while a shift is under way.
	a_bits_only_shifting: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_SHIFT_ALL && phase_q != PH_SHIFT_ROW) |-> (bits_q == '0))
		else $error("shift bit count left over outside a shift");

endmodule

FILE: hw/rtl/skd_cfg_regs.sv
// APB-style configuration register file holding the debounce tick count.
module skd_cfg_regs
	import skd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] debounce_ticks
);

	logic [15:0] debounce_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_DEBOUNCE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (wr_en) begin
			debounce_q <= pwdata[15:0];
		end
	end

	// Only the debounce register decodes; the other word reads as zero.
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_DEBOUNCE) begin
			prdata = {16'd0, debounce_q};
		end
	end

	assign debounce_ticks = debounce_q;

endmodule

FILE: test/shift_driven_keypad_scanner_test.sv
// Self-checking testbench for the shift-register driven keypad scanner.
module shift_driven_keypad_scanner_test;
	import skd_pkg::*;

	// Keypad geometry used for the instance and for the keypad emulation.
	localparam int KEY_ROWS = 5;
	localparam int KEY_COLS = 4;
	localparam logic [3:0] COL_MASK = 4'((1 << KEY_COLS) - 1);

	// Register addresses. Only the debounce register is mapped; the next slot
	// is an unmapped index whose writes must be dropped.
	localparam logic [2:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = {~REG_DEBOUNCE, 2'b00};

	// A handful of cycles covers the two register stages between the channels.
	localparam int DRAIN_CYCLES   = 8;
	// Cycles with no word moved on any channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Words of random traffic per configuration phase.
	localparam int PHASE_WORDS    = 70;
	localparam int PHASE_COUNT    = 3;

	// Legend printed on each key, row by row.
	localparam logic [7:0] KEY_LEGEND [KEY_COUNT] = '{
		"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
		".", "=", "+", "-", "*", "/", "^", "#", "s", 8'h00
	};

	// One result word as the scanner reports it for a single tick.
	typedef struct packed {
		logic       shift_clock;
		logic       shift_data;
		logic       busy_res;
		logic       scan_done;
		logic       key_found;
		logic [4:0] key_index;
		logic [7:0] key_char;
	} scan_word_t;

	// One directed scan: optional register writes, the keys held down, and the
	// verdict where it is plain from the key position.
	typedef struct packed {
		logic        write_cfg;
		logic [15:0] debounce;
		logic        stray_write;
		logic [19:0] keys;
		logic        bounce;
		logic        hold_start;
		logic        typed;
		logic        found;
		logic [4:0]  idx;
		logic [7:0]  ch;
	} scan_case_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        sink_ready = 1'b0;

	skd_in_if  scan_in_ch ();
	skd_out_if scan_out_ch ();

	assign scan_out_ch.ready = sink_ready;

	shift_driven_keypad_scanner #(
		.ROW_COUNT   (KEY_ROWS),
		.COLUMN_COUNT(KEY_COLS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scan_in (scan_in_ch),
		.scan_out(scan_out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicted scanner state and its copy of the debounce register.
	scan_phase_t sc_phase;
	logic [7:0]  sc_pattern;
	logic [3:0]  sc_bits;
	logic        sc_clk_half;
	logic [15:0] sc_wait;
	logic [3:0]  sc_captured;
	logic [2:0]  sc_row;
	logic [1:0]  sc_col;
	logic [15:0] sc_debounce;

	// Expected result words, oldest first.
	scan_word_t expected_words [$];

	// Emulated keypad: the keys held down and the outputs of the external shift
	// register, rebuilt from the predicted clock and data pins.
	logic [19:0] pressed_keys;
	logic [7:0]  row_latch;
	logic        last_shift_clock;
	logic        noise_on;

	// When set, the verdict fields of the next verdict word come from the table.
	logic       verdict_typed;
	logic       typed_found;
	logic [4:0] typed_index;
	logic [7:0] typed_char;

	int  error_count   = 0;
	int  results_seen  = 0;
	int  items_sent    = 0;
	int  burst_left    = 0;
	int  stall_cycles  = 0;
	bit  pause_pending = 1'b0;

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 50)
			$display("ERROR %0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want)
			report_error($sformatf("result %0d %s expected %0h got %0h",
				results_seen, name, want, got));
	endtask

	// First low column of the captured pattern at or above from.
	function automatic int first_low_column(input int from);
		for (int c = from; c < KEY_COLS; c++)
			if (!sc_captured[c])
				return c;
		return KEY_COLS;
	endfunction

	// Arm the shift of a pattern that pulls one row low.
	task automatic queue_row_pattern(input int r);
		sc_row     = 3'(r);
		sc_pattern = PATTERN_ALL_HIGH ^ (8'd1 << sc_row);
		sc_bits    = 4'(SHIFT_WIDTH);
		sc_phase   = PH_SHIFT_ROW;
	endtask

	// Advance the predicted scanner by one tick and return the word it reports.
	task automatic step_scanner(input logic start, input logic [3:0] levels,
		output scan_word_t w);
		logic [3:0] cols;
		int         c;
		cols          = levels & COL_MASK;
		w             = '0;
		w.shift_clock = sc_clk_half;
		w.shift_data  = sc_pattern[0];
		case (sc_phase)
			PH_IDLE: begin
				if (start) begin
					sc_pattern = PATTERN_ALL_LOW;
					sc_bits    = 4'(SHIFT_WIDTH);
					sc_phase   = PH_SHIFT_ALL;
				end
			end
			PH_SHIFT_ALL, PH_SHIFT_ROW: begin
				// Low half presents the bit, high half clocks it and rotates.
				w.shift_data = sc_pattern[7];
				if (sc_bits != 0 && sc_clk_half) begin
					w.shift_clock = 1'b0;
					sc_clk_half   = 1'b0;
				end else begin
					w.shift_clock = 1'b1;
					sc_clk_half   = 1'b1;
					sc_pattern    = {sc_pattern[6:0], sc_pattern[7]};
					if (sc_bits != 0)
						sc_bits--;
					if (sc_bits == 0)
						sc_phase = (sc_phase == PH_SHIFT_ALL) ? PH_SAMPLE : PH_CHECK_ROW;
				end
			end
			PH_SAMPLE: begin
				if (cols == COL_MASK) begin
					w.scan_done = 1'b1;
					sc_phase    = PH_IDLE;
				end else begin
					sc_captured = cols;
					sc_wait     = sc_debounce;
					sc_phase    = PH_WAIT;
				end
			end
			PH_WAIT: begin
				if (sc_wait != 0) begin
					sc_wait--;
				end else if (cols != sc_captured) begin
					w.scan_done = 1'b1;
					sc_phase    = PH_IDLE;
				end else begin
					c = first_low_column(0);
					if (c >= KEY_COLS) begin
						w.scan_done = 1'b1;
						sc_phase    = PH_IDLE;
					end else begin
						sc_col = 2'(c);
						queue_row_pattern(0);
					end
				end
			end
			PH_CHECK_ROW: begin
				if (cols == sc_captured) begin
					w.scan_done = 1'b1;
					w.key_found = 1'b1;
					w.key_index = 5'(int'(sc_row) * 4 + int'(sc_col));
					w.key_char  = (w.key_index < KEY_COUNT) ? KEY_LEGEND[w.key_index] : 8'h00;
					sc_phase    = PH_IDLE;
				end else if (int'(sc_row) + 1 < KEY_ROWS) begin
					queue_row_pattern(int'(sc_row) + 1);
				end else begin
					c = first_low_column(int'(sc_col) + 1);
					if (c >= KEY_COLS) begin
						w.scan_done = 1'b1;
						sc_phase    = PH_IDLE;
					end else begin
						sc_col = 2'(c);
						queue_row_pattern(0);
					end
				end
			end
			default: sc_phase = PH_IDLE;
		endcase
		w.busy_res = (sc_phase != PH_IDLE);
	endtask

	// Column levels seen through the matrix: a column reads low when a held key
	// joins it to a row that the shift register is pulling low.
	function automatic logic [3:0] keypad_columns(input logic [19:0] keys,
		input logic [7:0] rows);
		logic [3:0] cols;
		cols = 4'hF;
		for (int r = 0; r < KEY_ROWS; r++)
			for (int c = 0; c < KEY_COLS; c++)
				if (keys[r * 4 + c] && !rows[r])
					cols[c] = 1'b0;
		return cols;
	endfunction

	// Mostly single keys, sometimes none, two, or an arbitrary set.
	function automatic logic [19:0] pick_keys();
		case ($urandom_range(0, 9))
			0:       return 20'h0;
			7, 8:    return (20'd1 << $urandom_range(0, 19)) | (20'd1 << $urandom_range(0, 19));
			9:       return 20'($urandom);
			default: return 20'd1 << $urandom_range(0, 19);
		endcase
	endfunction

	// Send one tick word, predict its result once accepted, then idle between
	// bursts. A pending pause holds the channel until every result is back.
	task automatic send_tick(input logic start);
		scan_word_t w;
		logic [3:0] cols;
		int         gap;
		cols = keypad_columns(pressed_keys, row_latch);
		if (noise_on && $urandom_range(0, 49) == 0)
			cols = cols ^ (4'b0001 << $urandom_range(0, 3));
		scan_in_ch.valid         <= 1'b1;
		scan_in_ch.start_scan    <= start;
		scan_in_ch.column_levels <= cols;
		do @(posedge clk); while (scan_in_ch.ready !== 1'b1);
		items_sent++;
		step_scanner(start, cols, w);
		if (w.scan_done && verdict_typed) begin
			w.key_found = typed_found;
			w.key_index = typed_index;
			w.key_char  = typed_char;
		end
		expected_words.push_back(w);
		// The external register shifts on a rising edge of its clock pin.
		if (w.shift_clock && !last_shift_clock)
			row_latch = {row_latch[6:0], w.shift_data};
		last_shift_clock = w.shift_clock;
		if (pause_pending && sc_phase != PH_IDLE) begin
			pause_pending = 1'b0;
			scan_in_ch.valid <= 1'b0;
			while (expected_words.size() != 0)
				@(posedge clk);
			@(posedge clk);
		end else if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				scan_in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// One complete scan: a few idle ticks, the start tick, then ticks until the
	// scanner is idle again. A bounce swaps the held keys during the debounce wait.
	task automatic run_scan(input logic [19:0] keys, input logic bounce,
		input logic [19:0] keys_after, input int busy_start_pct, input logic churn);
		int idle_ticks;
		pressed_keys = keys;
		idle_ticks   = $urandom_range(0, 2);
		repeat (idle_ticks) send_tick(1'b0);
		send_tick(1'b1);
		while (sc_phase != PH_IDLE) begin
			if (bounce && sc_phase == PH_WAIT)
				pressed_keys = keys_after;
			if (churn && $urandom_range(0, 299) == 0)
				pressed_keys = pick_keys();
			send_tick($urandom_range(0, 99) < busy_start_pct);
		end
	endtask

	// Hold the tick channel and wait until every expected result has arrived.
	task automatic settle_scanner();
		scan_in_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Write a register and, when it is the debounce register, read it back through the same select.
	task automatic program_register(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_DEBOUNCE) begin
			sc_debounce = data[15:0];
			penable <= 1'b0;
			pwrite  <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
			if (prdata[15:0] !== sc_debounce)
				report_error($sformatf("debounce readback expected %0d got %0d",
					sc_debounce, prdata[15:0]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Result side: the sink stalls on a rotating pattern, from always ready through
	// random and periodic stalls.
	int sink_cycle = 0;

	always @(posedge clk) begin
		scan_word_t got;
		scan_word_t want;
		if (scan_out_ch.valid === 1'b1 && sink_ready) begin
			got = '{scan_out_ch.shift_clock, scan_out_ch.shift_data, scan_out_ch.busy_res,
				scan_out_ch.scan_done, scan_out_ch.key_found, scan_out_ch.key_index,
				scan_out_ch.key_char};
			if (expected_words.size() == 0) begin
				report_error($sformatf("result word %0d with nothing expected", results_seen));
			end else begin
				want = expected_words.pop_front();
				compare_field("shift_clock", 8'(want.shift_clock), 8'(got.shift_clock));
				compare_field("shift_data", 8'(want.shift_data), 8'(got.shift_data));
				compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				compare_field("scan_done", 8'(want.scan_done), 8'(got.scan_done));
				compare_field("key_found", 8'(want.key_found), 8'(got.key_found));
				compare_field("key_index", 8'(want.key_index), 8'(got.key_index));
				compare_field("key_char", want.key_char, got.key_char);
			end
			results_seen++;
		end
		sink_cycle++;
		case ((sink_cycle >> 8) % 4)
			0:       sink_ready <= 1'b1;
			1:       sink_ready <= ($urandom_range(0, 3) != 0);
			2:       sink_ready <= ((sink_cycle % 9) < 6);
			default: sink_ready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Any word moved on either channel, or a register access, counts as progress.
	always @(posedge clk) begin
		if ((scan_in_ch.valid === 1'b1 && scan_in_ch.ready === 1'b1) ||
			(scan_out_ch.valid === 1'b1 && sink_ready) ||
			(psel === 1'b1 && penable === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("FAIL shift_driven_keypad_scanner");
		$finish;
	end

	scan_case_t scan_cases [11];

	initial begin
		scan_case_t sc;

		// Directed scans. The first one runs with the debounce at its reset value;
		// no key is held, so the long wait is never entered. The typed verdicts
		// follow directly from the key position.
		//            cfg   debounce   stray keys       bnc   hold  typed found idx   char
		scan_cases = '{
			'{1'b0, 16'd0,     1'b0, 20'h00000, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0,  8'h00},
			'{1'b1, 16'd0,     1'b0, 20'h00001, 1'b0, 1'b0, 1'b1, 1'b1, 5'd0,  "0"},
			'{1'b0, 16'd0,     1'b0, 20'h80000, 1'b0, 1'b0, 1'b1, 1'b1, 5'd19, 8'h00},
			'{1'b0, 16'd0,     1'b0, 20'h10000, 1'b0, 1'b0, 1'b1, 1'b1, 5'd16, "^"},
			'{1'b1, 16'd1,     1'b0, 20'h00001, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0,  8'h00},
			'{1'b0, 16'd0,     1'b0, 20'h04040, 1'b0, 1'b0, 1'b1, 1'b1, 5'd6,  "6"},
			'{1'b0, 16'd0,     1'b0, 20'h00108, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0,  8'h00},
			'{1'b0, 16'd0,     1'b0, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0,  8'h00},
			'{1'b1, 16'd3,     1'b0, 20'h00004, 1'b0, 1'b1, 1'b1, 1'b1, 5'd2,  "2"},
			'{1'b0, 16'd0,     1'b1, 20'h00010, 1'b0, 1'b0, 1'b1, 1'b1, 5'd4,  "4"},
			'{1'b1, 16'hFFFF,  1'b0, 20'h00000, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0,  8'h00}
		};

		// Every input is at a known level before the first edge.
		arst_n                   <= 1'b0;
		psel                     <= 1'b0;
		penable                  <= 1'b0;
		pwrite                   <= 1'b0;
		paddr                    <= '0;
		pwdata                   <= '0;
		scan_in_ch.valid         <= 1'b0;
		scan_in_ch.start_scan    <= 1'b0;
		scan_in_ch.column_levels <= 4'hF;

		// Predictor after reset: idle, clock pin high, data pin low.
		sc_phase         = PH_IDLE;
		sc_pattern       = PATTERN_ALL_LOW;
		sc_bits          = '0;
		sc_clk_half      = 1'b1;
		sc_wait          = '0;
		sc_captured      = COL_MASK;
		sc_row           = '0;
		sc_col           = '0;
		sc_debounce      = DEBOUNCE_RESET;
		pressed_keys     = '0;
		row_latch        = 8'hFF;
		last_shift_clock = 1'b1;
		noise_on         = 1'b0;
		verdict_typed    = 1'b0;
		typed_found      = 1'b0;
		typed_index      = '0;
		typed_char       = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Register writes only happen with the scanner settled, so
		// the debounce value changes between scans and never inside one. The stray
		// write goes to an unmapped index and must leave the debounce untouched.
		for (int i = 0; i < $size(scan_cases); i++) begin
			sc = scan_cases[i];
			if (sc.write_cfg || sc.stray_write)
				settle_scanner();
			if (sc.write_cfg)
				program_register(ADDR_DEBOUNCE, 32'(sc.debounce));
			if (sc.stray_write)
				program_register(ADDR_UNMAPPED, 32'h0000_0001);
			verdict_typed = sc.typed;
			typed_found   = sc.found;
			typed_index   = sc.idx;
			typed_char    = sc.ch;
			run_scan(sc.keys, sc.bounce, 20'h0, sc.hold_start ? 100 : 0, 1'b0);
			verdict_typed = 1'b0;
		end

		// Random part: well-formed scans against the emulated keypad, with random
		// keys, occasional bounces, key changes mid-scan, stray start requests and
		// pin noise. Each phase runs with its own short debounce; every phase but the last pauses
		// the sender mid-scan until all results are back.
		noise_on = 1'b1;
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			settle_scanner();
			program_register(ADDR_DEBOUNCE,
				(phase == 1) ? $urandom_range(8, 40) : $urandom_range(0, 6));
			pause_pending = (phase != 2);
			begin
				int stop_at;
				stop_at = items_sent + PHASE_WORDS;
				while (items_sent < stop_at)
					run_scan(pick_keys(), $urandom_range(0, 5) == 0, pick_keys(),
						($urandom_range(0, 2) == 0) ? 30 : 0, 1'b1);
			end
		end

		// Let the last results drain, then give the pipeline time to show any
		// word it should not produce.
		settle_scanner();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_words.size() == 0)
			$display("PASS shift_driven_keypad_scanner");
		else
			$display("FAIL shift_driven_keypad_scanner");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/skd_pkg.sv
hw/rtl/skd_in_if.sv
hw/rtl/skd_out_if.sv
hw/rtl/skd_cfg_regs.sv
hw/rtl/shift_driven_keypad_scanner.sv
test/shift_driven_keypad_scanner_test.sv
